@@ rtl/aahs_pkg.sv @@
// Shared types and constants for the accessory authentication handshake block.
// No dependencies; aahs_step and the top level import this package.
package aahs_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_CERTREQ  = 3'd1,
        PH_CERTSENT = 3'd2,
        PH_CHALRECV = 3'd3,
        PH_SIGNED   = 3'd4,
        PH_COMPLETE = 3'd5,
        PH_ERROR    = 3'd6
    } phase_t;

    localparam logic [1:0] MODE_MSG   = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    localparam logic [15:0] ID_CERT_REQ  = 16'hAA00;
    localparam logic [15:0] ID_CHAL_REQ  = 16'hAA02;
    localparam logic [15:0] ID_SUCCEEDED = 16'hAA04;
    localparam logic [15:0] ID_FAILED    = 16'hAA05;

    localparam logic [15:0] TLV_HDR_LEN   = 16'd4;
    localparam logic [15:0] MAX_CHALLENGE = 16'd256;

    localparam logic CFG_MAX_RETRIES   = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    localparam logic [3:0] MAX_RETRIES_RST   = 4'd3;
    localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd5;
    localparam logic [7:0] TICKS_SAT         = 8'hFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] msg_id;
        logic [15:0] tlv_length;
        logic [15:0] payload_len;
        logic        cert_ok;
        logic        sign_ok;
    } item_t;

    typedef struct packed {
        logic       refused;
        logic       cert_tx;
        logic       send_response;
        logic [8:0] challenge_length;
        logic       done_valid;
        logic       done_pass;
        logic [2:0] phase_now;
        logic [3:0] retries_used;
    } result_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] retry_counter;
        logic [7:0] idle_ticks;
    } state_t;

    typedef struct packed {
        logic [3:0] max_retries;
        logic [7:0] timeout_ticks;
    } cfg_t;

endpackage

@@ rtl/aahs_item_if.sv @@
// Input item channel of the authentication handshake block.
// Plain valid/ready handshake; field widths follow the item format.
interface aahs_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] msg_id;
    logic [15:0] tlv_length;
    logic [15:0] payload_len;
    logic        cert_ok;
    logic        sign_ok;

    modport source (output valid, mode, msg_id, tlv_length, payload_len, cert_ok, sign_ok,
                    input ready);
    modport sink (input valid, mode, msg_id, tlv_length, payload_len, cert_ok, sign_ok,
                  output ready);
endinterface

@@ rtl/aahs_result_if.sv @@
// Result item channel of the authentication handshake block.
// Plain valid/ready handshake; field widths follow the result format.
interface aahs_result_if;
    logic       valid;
    logic       ready;
    logic       refused;
    logic       cert_tx;
    logic       send_response;
    logic [8:0] challenge_length;
    logic       done_valid;
    logic       done_pass;
    logic [2:0] phase_now;
    logic [3:0] retries_used;

    modport source (output valid, refused, cert_tx, send_response, challenge_length,
                    done_valid, done_pass, phase_now, retries_used,
                    input ready);
    modport sink (input valid, refused, cert_tx, send_response, challenge_length,
                  done_valid, done_pass, phase_now, retries_used,
                  output ready);
endinterface

@@ rtl/aahs_cfg_if.sv @@
// Configuration write channel: register index and write data with valid/ready.
// Index 0 is max_retries, index 1 is timeout_ticks.
interface aahs_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/aahs_step.sv @@
// Combinational step of the handshake controller: next state and result
// for one item. Depends on aahs_pkg.
module aahs_step (
    input  aahs_pkg::item_t   item,
    input  aahs_pkg::state_t  cur,
    input  aahs_pkg::cfg_t    cfg,
    output aahs_pkg::state_t  nxt,
    output aahs_pkg::result_t res
);
    import aahs_pkg::*;

    logic        can_retry;
    logic [3:0]  retry_inc;
    logic [15:0] chal;
    logic        chal_bad;
    logic [7:0]  ticks_inc;
    logic [7:0]  limit;
    logic        tick_active;

    assign can_retry = cur.retry_counter < cfg.max_retries;
    assign retry_inc = cur.retry_counter + 4'd1;
    assign chal      = item.tlv_length - TLV_HDR_LEN;
    assign chal_bad  = (item.payload_len < TLV_HDR_LEN) || (item.tlv_length < TLV_HDR_LEN)
                    || (item.tlv_length > item.payload_len)
                    || (chal == 16'd0) || (chal > MAX_CHALLENGE);
    assign ticks_inc = (cur.idle_ticks == TICKS_SAT) ? TICKS_SAT : cur.idle_ticks + 8'd1;
    assign limit     = (cfg.timeout_ticks == 8'd0) ? 8'd1 : cfg.timeout_ticks;
    assign tick_active = (cur.phase != PH_IDLE) && (cur.phase != PH_COMPLETE)
                      && (cur.phase != PH_ERROR);

    always_comb
    begin
        state_t  s;
        result_t r;
        s = cur;
        r = '0;
        case (item.mode)
            MODE_MSG:
            begin
                case (item.msg_id)
                    ID_CERT_REQ:
                    begin
                        if (cur.phase == PH_CERTREQ || cur.phase == PH_CERTSENT)
                        begin
                            if (!item.cert_ok)
                            begin
                                s.phase = PH_ERROR;
                                s.idle_ticks = '0;
                                r.done_valid = 1'b1;
                            end
                            else
                            begin
                                r.cert_tx = 1'b1;
                                s.retry_counter = '0;
                                s.phase = PH_CERTSENT;
                                s.idle_ticks = '0;
                            end
                        end
                    end
                    ID_CHAL_REQ:
                    begin
                        if (cur.phase == PH_CERTSENT || cur.phase == PH_CHALRECV)
                        begin
                            s.phase = PH_CHALRECV;
                            s.idle_ticks = '0;
                            if (chal_bad)
                            begin
                                s.phase = PH_ERROR;
                                r.done_valid = 1'b1;
                            end
                            else
                            begin
                                r.challenge_length = chal[8:0];
                                if (item.sign_ok)
                                begin
                                    r.send_response = 1'b1;
                                    s.retry_counter = '0;
                                    s.phase = PH_SIGNED;
                                end
                                else if (can_retry)
                                begin
                                    s.retry_counter = retry_inc;
                                end
                                else
                                begin
                                    s.phase = PH_ERROR;
                                    r.done_valid = 1'b1;
                                end
                            end
                        end
                    end
                    ID_SUCCEEDED:
                    begin
                        s.phase = PH_COMPLETE;
                        s.idle_ticks = '0;
                        r.done_valid = 1'b1;
                        r.done_pass = 1'b1;
                    end
                    ID_FAILED:
                    begin
                        s.idle_ticks = '0;
                        if (can_retry)
                        begin
                            s.retry_counter = retry_inc;
                            s.phase = PH_CERTREQ;
                        end
                        else
                        begin
                            s.phase = PH_ERROR;
                            r.done_valid = 1'b1;
                        end
                    end
                    default:
                    begin
                        r.refused = 1'b1;
                    end
                endcase
            end
            MODE_TICK:
            begin
                if (tick_active)
                begin
                    if (ticks_inc < limit)
                    begin
                        s.idle_ticks = ticks_inc;
                    end
                    else if (can_retry)
                    begin
                        s.retry_counter = retry_inc;
                        s.idle_ticks = '0;
                        r.cert_tx = (cur.phase == PH_CERTSENT) && item.cert_ok;
                    end
                    else
                    begin
                        s.phase = PH_ERROR;
                        s.idle_ticks = '0;
                        r.done_valid = 1'b1;
                    end
                end
            end
            MODE_START:
            begin
                if (cur.phase != PH_IDLE)
                begin
                    r.refused = 1'b1;
                end
                else
                begin
                    s.retry_counter = '0;
                    s.phase = PH_CERTREQ;
                    s.idle_ticks = '0;
                end
            end
            default:
            begin
                s = cur;
            end
        endcase
        r.phase_now = s.phase;
        r.retries_used = s.retry_counter;
        nxt = s;
        res = r;
    end

endmodule

@@ rtl/accessory_auth_handshake_fsm.sv @@
// Accessory authentication handshake controller, top level.
// Path: input register, result register; phase/retry/tick update is combinational.
// Throughput: one item per cycle while result_out is not stalled.
// Reset: phase idle, counters zero, max_retries 3, timeout_ticks 5, both channels empty.
// Depends on aahs_pkg, aahs_item_if, aahs_result_if, aahs_cfg_if and aahs_step.
module accessory_auth_handshake_fsm (
    input  logic          clk,
    input  logic          rst_n,
    aahs_item_if.sink     item_in,
    aahs_result_if.source result_out,
    aahs_cfg_if.sink      cfg
);
    import aahs_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    logic    res_valid_reg;
    result_t res_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    cfg_t    cfg_reg;
    item_t   item_bus;
    logic    advance;
    logic    fire;

    assign item_bus = '{mode: item_in.mode, msg_id: item_in.msg_id,
                        tlv_length: item_in.tlv_length, payload_len: item_in.payload_len,
                        cert_ok: item_in.cert_ok, sign_ok: item_in.sign_ok};

    // result stage moves when empty or drained this cycle
    assign advance       = !res_valid_reg || result_out.ready;
    assign fire          = in_valid_reg && advance;
    assign item_in.ready = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;

    aahs_step u_step (
        .item (item_reg),
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_IDLE, retry_counter: 4'd0, idle_ticks: 8'd0};
            cfg_reg       <= '{max_retries: MAX_RETRIES_RST, timeout_ticks: TIMEOUT_TICKS_RST};
        end
        else
        begin
            if (item_in.ready)
                in_valid_reg <= item_in.valid;
            if (advance)
                res_valid_reg <= in_valid_reg;
            if (fire)
                state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_MAX_RETRIES:   cfg_reg.max_retries   <= cfg.data[3:0];
                    CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg.data;
                    default:           cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
            item_reg <= item_bus;
        if (fire)
            res_reg <= res_next;
    end

    assign result_out.valid            = res_valid_reg;
    assign result_out.refused          = res_reg.refused;
    assign result_out.cert_tx          = res_reg.cert_tx;
    assign result_out.send_response    = res_reg.send_response;
    assign result_out.challenge_length = res_reg.challenge_length;
    assign result_out.done_valid       = res_reg.done_valid;
    assign result_out.done_pass        = res_reg.done_pass;
    assign result_out.phase_now        = res_reg.phase_now;
    assign result_out.retries_used     = res_reg.retries_used;

endmodule
